[sv/line_track_steer_speed_macros.svh]
// Assertion macros shared by the line tracker checker
`ifndef LINE_TRACK_STEER_SPEED_MACROS_SVH
`define LINE_TRACK_STEER_SPEED_MACROS_SVH

// same-cycle implication, quiet during reset
`define LTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, quiet during reset
`define LTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[sv/lts_pkg.sv]
// Shared types, widths, constants and pattern table of the line tracker
package lts_pkg;

  localparam int ERR_FULL_SCALE = 18;

  localparam int PAT_W      = 8;
  localparam int ANG_W      = 17;
  localparam int TIME_W     = 32;
  localparam int ERR_W      = 6;
  localparam int TURN_W     = 16;
  localparam int SPD_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int LIM_W      = 15;
  localparam int COEF_W     = 9;
  localparam int IDLE_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // error magnitude after the full-scale clamp
  localparam int M_W = ($clog2(ERR_FULL_SCALE + 1) > 5) ? $clog2(ERR_FULL_SCALE + 1) : 5;

  // shared bit-serial multiplier
  localparam int MUL_A_W   = 33;
  localparam int MUL_B_W   = 17;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

  // drop = base * slow * m / (256 * full scale)
  localparam int DROP_DIV  = 256 * ERR_FULL_SCALE;
  localparam int DIVD_W    = 2 * SPD_W + M_W;
  localparam int REM_W     = $clog2(DROP_DIV) + 1;
  localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

  localparam int SUM_W = 28;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ERR_GAIN    = 3'd0,
    CFG_FF_GAIN     = 3'd1,
    CFG_TURN_LIMIT  = 3'd2,
    CFG_BASE_SPEED  = 3'd3,
    CFG_SLOW_FACTOR = 3'd4,
    CFG_BRAKE_COEF  = 3'd5,
    CFG_ACCEL_COEF  = 3'd6,
    CFG_IDLE_LIMIT  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_ctl_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] p;
  } mul_res_t;

  function automatic logic signed [ERR_W-1:0] lookup_error(logic [PAT_W-1:0] pat);
    logic signed [ERR_W-1:0] e;
    case (pat)
      8'he7:   e = 6'sd0;
      8'hcf:   e = 6'sd7;
      8'h9f:   e = 6'sd10;
      8'h3f:   e = 6'sd12;
      8'hf3:   e = -6'sd7;
      8'hf9:   e = -6'sd10;
      8'hfc:   e = -6'sd12;
      8'hef:   e = 6'sd4;
      8'hdf:   e = 6'sd6;
      8'hbf:   e = 6'sd7;
      8'h7f:   e = 6'sd14;
      8'hf7:   e = -6'sd4;
      8'hfb:   e = -6'sd6;
      8'hfd:   e = -6'sd9;
      8'hfe:   e = -6'sd14;
      8'h1f:   e = 6'sd16;
      8'hf8:   e = -6'sd6;
      8'h8f:   e = 6'sd18;
      default: e = 6'sd0;
    endcase
    return e;
  endfunction

endpackage

[sv/lts_in_if.sv]
// Tick request channel: sensor pattern, camera angle and timestamp
interface lts_in_if;
  import lts_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [PAT_W-1:0]         gray_pattern;
  logic                     angle_valid;
  logic signed [ANG_W-1:0]  line_angle;
  logic [TIME_W-1:0]        now_ms;
  modport source (output valid, gray_pattern, angle_valid, line_angle, now_ms, input ready);
  modport sink (input valid, gray_pattern, angle_valid, line_angle, now_ms, output ready);
endinterface

[sv/lts_out_if.sv]
// Result channel: track error, turn rate and drive speed
interface lts_out_if;
  import lts_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ERR_W-1:0]  track_error;
  logic signed [TURN_W-1:0] turn_rate;
  logic [SPD_W-1:0]         drive_speed;
  modport source (output valid, track_error, turn_rate, drive_speed, input ready);
  modport sink (input valid, track_error, turn_rate, drive_speed, output ready);
endinterface

[sv/lts_cfg_if.sv]
// Register write channel
interface lts_cfg_if;
  import lts_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/line_track_steer_speed.sv]
// Line tracker: pattern to error, turn rate and smoothed speed per control tick
// One tick runs from request to result through five products on a shared
// bit-serial multiplier, each opened and closed by a start and done handshake, a
// 37-step restoring divide for the speed drop and the glue states S_TGT, S_SMP and
// S_DONE. The next request is taken on the cycle after the result is loaded, even
// while that result still waits on the output register; a result held longer than a
// whole tick stalls the next one in its last step.
module line_track_steer_speed (
  input logic        clk,
  input logic        rst,
  lts_in_if.sink     tick,
  lts_out_if.source  result,
  lts_cfg_if.sink    cfg
);
  import lts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FB, S_FF, S_BS, S_BSM, S_DIV, S_TGT, S_SMP, S_SM, S_DONE
  } state_t;

  state_t state;

  // registers
  logic signed [GAIN_W-1:0] err_gain, ff_gain;
  logic [LIM_W-1:0]         turn_limit;
  logic [SPD_W-1:0]         base_speed, slow_factor;
  logic [COEF_W-1:0]        brake_coef, accel_coef;
  logic [IDLE_W-1:0]        idle_limit_ms;

  logic [SPD_W-1:0]         smooth_speed;
  logic [TIME_W-1:0]        last_time;

  logic signed [ERR_W-1:0]  e_r;
  logic                     ang_ok;
  logic signed [ANG_W-1:0]  angle_r;
  logic                     neg_r;
  logic signed [SUM_W-1:0]  fb_r;
  logic signed [TURN_W-1:0] turn_r;
  logic [SPD_W-1:0]         tgt_r;
  logic [DIVD_W-1:0]        divq;
  logic [REM_W-1:0]         rem;
  logic [DIV_CNT_W-1:0]     div_cnt;

  logic                     out_valid;
  logic signed [ERR_W-1:0]  out_err;
  logic signed [TURN_W-1:0] out_turn;
  logic [SPD_W-1:0]         out_spd;

  mul_ctl_t mul_ctl;
  mul_res_t mul_res;

  lts_serial_mul u_mul (
    .clk (clk),
    .rst (rst),
    .ctl (mul_ctl),
    .res (mul_res)
  );

  function automatic logic [MUL_A_W-1:0] mag_of(logic signed [MUL_A_W-1:0] v);
    return v[MUL_A_W-1] ? MUL_A_W'(-v) : MUL_A_W'(v);
  endfunction

  // combinational helpers
  logic signed [ERR_W-1:0]  e_neg;
  logic [M_W-1:0]           e_mag, m_sel;
  logic [TIME_W-1:0]        gap;
  logic                     gap_long;
  logic signed [SUM_W-1:0]  fb_val, ff_val, w_sum, lim_s, w_clamp;
  logic [SUM_W-1:0]         fb_half, ff_mag;
  logic [REM_W-1:0]         rem_sh;
  logic                     q_bit;
  logic signed [SPD_W:0]    diff;
  logic [SPD_W+1:0]         delta;
  logic signed [SPD_W+2:0]  nxt;
  logic [SPD_W-1:0]         nxt_sat;

  always_comb begin
    e_neg   = -e_r;
    e_mag   = M_W'(e_r[ERR_W-1] ? e_neg : e_r);
    m_sel   = (e_mag > M_W'(ERR_FULL_SCALE)) ? M_W'(ERR_FULL_SCALE) : e_mag;
    gap      = tick.now_ms - last_time;
    gap_long = gap > TIME_W'(idle_limit_ms);

    // truncation toward zero: shift the magnitude, then restore the sign
    fb_half = SUM_W'(mul_res.p[MUL_P_W-1:1]);
    fb_val  = neg_r ? -$signed(fb_half) : $signed(fb_half);
    ff_mag  = SUM_W'(mul_res.p[MUL_P_W-1:8]);
    ff_val  = neg_r ? -$signed(ff_mag) : $signed(ff_mag);
    w_sum   = fb_r + (ang_ok ? ff_val : '0);
    lim_s   = $signed(SUM_W'(turn_limit));
    if (w_sum > lim_s)
      w_clamp = lim_s;
    else if (w_sum < -lim_s)
      w_clamp = -lim_s;
    else
      w_clamp = w_sum;

    rem_sh = {rem[REM_W-2:0], divq[DIVD_W-1]};
    q_bit  = rem_sh >= REM_W'(DROP_DIV);

    diff    = $signed({1'b0, tgt_r}) - $signed({1'b0, smooth_speed});
    delta   = (SPD_W + 2)'(mul_res.p[MUL_P_W-1:8]);
    nxt     = $signed({3'b0, smooth_speed}) +
              (neg_r ? -$signed({1'b0, delta}) : $signed({1'b0, delta}));
    if (nxt < 0)
      nxt_sat = '0;
    else if (nxt > $signed((SPD_W + 3)'({SPD_W{1'b1}})))
      nxt_sat = '1;
    else
      nxt_sat = SPD_W'(nxt);
  end

  assign tick.ready         = (state == S_IDLE);
  assign cfg.ready          = 1'b1;
  assign result.valid       = out_valid;
  assign result.track_error = out_err;
  assign result.turn_rate   = out_turn;
  assign result.drive_speed = out_spd;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      err_gain      <= 16'sd26;
      ff_gain       <= -16'sd15;
      turn_limit    <= 15'd512;
      base_speed    <= 16'd256;
      slow_factor   <= 16'd128;
      brake_coef    <= 9'd64;
      accel_coef    <= 9'd16;
      idle_limit_ms <= 16'd500;
    end else if (cfg.valid) begin
      case (cfg_idx_t'(cfg.index))
        CFG_ERR_GAIN:    err_gain      <= $signed(cfg.data);
        CFG_FF_GAIN:     ff_gain       <= $signed(cfg.data);
        CFG_TURN_LIMIT:  turn_limit    <= cfg.data[LIM_W-1:0];
        CFG_BASE_SPEED:  base_speed    <= cfg.data;
        CFG_SLOW_FACTOR: slow_factor   <= cfg.data;
        CFG_BRAKE_COEF:  brake_coef    <= cfg.data[COEF_W-1:0];
        CFG_ACCEL_COEF:  accel_coef    <= cfg.data[COEF_W-1:0];
        CFG_IDLE_LIMIT:  idle_limit_ms <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      mul_ctl.start <= 1'b0;
      smooth_speed  <= '0;
      last_time     <= '0;
      div_cnt       <= '0;
    end else begin
      mul_ctl.start <= (state == S_IDLE && tick.valid) ||
                       ((state == S_FB || state == S_FF || state == S_BS) && mul_res.done) ||
                       (state == S_SMP);
      if (state == S_DONE && (!out_valid || result.ready))
        out_valid <= 1'b1;
      else if (result.valid && result.ready)
        out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (tick.valid) begin
            e_r       <= lookup_error(tick.gray_pattern);
            ang_ok    <= tick.angle_valid;
            angle_r   <= tick.line_angle;
            last_time <= tick.now_ms;
            if (gap_long)
              smooth_speed <= '0;
            mul_ctl.a     <= mag_of(MUL_A_W'(err_gain));
            mul_ctl.b     <= MUL_B_W'(mag_of(MUL_A_W'(lookup_error(tick.gray_pattern))));
            neg_r         <= err_gain[GAIN_W-1] ^ lookup_error(tick.gray_pattern)[ERR_W-1];
            state         <= S_FB;
          end
        end
        S_FB: begin
          if (mul_res.done) begin
            fb_r          <= fb_val;
            mul_ctl.a     <= mag_of(MUL_A_W'(angle_r));
            mul_ctl.b     <= MUL_B_W'(mag_of(MUL_A_W'(ff_gain)));
            neg_r         <= angle_r[ANG_W-1] ^ ff_gain[GAIN_W-1];
            state         <= S_FF;
          end
        end
        S_FF: begin
          if (mul_res.done) begin
            turn_r        <= TURN_W'(w_clamp);
            mul_ctl.a     <= MUL_A_W'(base_speed);
            mul_ctl.b     <= MUL_B_W'(slow_factor);
            state         <= S_BS;
          end
        end
        S_BS: begin
          if (mul_res.done) begin
            mul_ctl.a     <= MUL_A_W'(mul_res.p[2*SPD_W-1:0]);
            mul_ctl.b     <= MUL_B_W'(m_sel);
            state         <= S_BSM;
          end
        end
        S_BSM: begin
          if (mul_res.done) begin
            divq    <= mul_res.p[DIVD_W-1:0];
            rem     <= '0;
            div_cnt <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          rem     <= q_bit ? rem_sh - REM_W'(DROP_DIV) : rem_sh;
          divq    <= {divq[DIVD_W-2:0], q_bit};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_CNT_W'(DIVD_W - 1))
            state <= S_TGT;
        end
        S_TGT: begin
          tgt_r <= (divq >= DIVD_W'(base_speed)) ? '0 : base_speed - SPD_W'(divq);
          state <= S_SMP;
        end
        S_SMP: begin
          mul_ctl.a     <= mag_of(MUL_A_W'(diff));
          mul_ctl.b     <= MUL_B_W'(diff[SPD_W] ? brake_coef : accel_coef);
          neg_r         <= diff[SPD_W];
          state         <= S_SM;
        end
        S_SM: begin
          if (mul_res.done) begin
            smooth_speed <= nxt_sat;
            state        <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || result.ready) begin
            out_err   <= e_r;
            out_turn  <= turn_r;
            out_spd   <= smooth_speed;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/lts_serial_mul.sv]
// Unsigned shift-add multiplier, one multiplier bit per cycle
module lts_serial_mul (
  input  logic              clk,
  input  logic              rst,
  input  lts_pkg::mul_ctl_t ctl,
  output lts_pkg::mul_res_t res
);
  import lts_pkg::*;

  logic [MUL_P_W-1:0]   acc;
  logic [MUL_A_W-1:0]   mcand;
  logic [MUL_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [MUL_A_W:0]     sum;
  logic [MUL_P_W-1:0]   acc_next;

  always_comb begin
    sum      = {1'b0, acc[MUL_P_W-1:MUL_B_W]} + (acc[0] ? {1'b0, mcand} : '0);
    acc_next = {sum, acc[MUL_B_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mcand <= ctl.a;
      acc   <= {{MUL_A_W{1'b0}}, ctl.b};
    end else if (busy) begin
      acc <= acc_next;
    end
  end

  assign res.done = done;
  assign res.p    = acc;

endmodule

[sv/lts_checker.sv]
// Port-level checks of the line tracker, bound to the top level
`include "line_track_steer_speed_macros.svh"

module lts_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         tick_valid,
  input logic                         tick_ready,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [lts_pkg::ERR_W-1:0]    res_err,
  input logic [lts_pkg::SPD_W-1:0]    res_spd
);
  import lts_pkg::*;

  // a stalled result keeps its speed
  `LTS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_spd))
  // one tick in the works at a time
  `LTS_ASSERT_NEXT(a_one_tick, tick_valid && tick_ready, !tick_ready)
  // error magnitude stays within the full scale of the pattern table, 18
  `LTS_ASSERT_NOW(a_err_range, res_valid, ($signed(res_err) <= 6'sd18) && ($signed(res_err) >= -6'sd18))

endmodule

bind line_track_steer_speed lts_checker u_lts_checker (
  .clk        (clk),
  .rst        (rst),
  .tick_valid (tick.valid),
  .tick_ready (tick.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_err    (result.track_error),
  .res_spd    (result.drive_speed)
);
